// ----- hw/rtl/haar_feature_evaluator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Haar feature evaluator assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef HAAR_FEATURE_EVALUATOR_CORE_DEFINES_SVH
`define HAAR_FEATURE_EVALUATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HFE_ASSERT_NEVER(lbl, cond, msg) \
  `HFE_ASSERT(lbl, !(cond), msg)
`else
`define HFE_ASSERT(lbl, prop, msg)
`define HFE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/hfe_pkg.sv -----
// ----------------------------------------------------------------------------
// Haar feature evaluator package
// Payload types, command and corner types, and the per-feature corner tables.
// ----------------------------------------------------------------------------
`default_nettype none

package hfe_pkg;

  localparam int DEFAULT_WINDOW_SIZE = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int VALUE_W = 18;
  localparam int ACC_W = 24;

  localparam logic [2:0] KIND_H2 = 3'd0;
  localparam logic [2:0] KIND_V2 = 3'd1;
  localparam logic [2:0] KIND_H3 = 3'd2;
  localparam logic [2:0] KIND_V3 = 3'd3;
  localparam logic [2:0] KIND_F4 = 3'd4;

  localparam logic REQ_LOAD = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic [9:0]  load_index;
    logic [17:0] load_value;
    logic [2:0]  feature_kind;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic [4:0]  scale_x;
    logic [4:0]  scale_y;
  } in_t;

  typedef struct packed {
    logic signed [19:0] feature_value;
    logic               out_of_window;
  } out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic        is_load;
    logic        load_ok;
    logic [9:0]  load_index;
    logic [17:0] load_value;
    logic        skip;
    logic        oow;
    logic [2:0]  kind;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic [4:0]  scale_x;
    logic [4:0]  scale_y;
  } cmd_t;

  typedef enum logic [2:0] {
    COEF_P1,
    COEF_M1,
    COEF_P2,
    COEF_M2,
    COEF_P4
  } coef_e;

  typedef struct packed {
    logic       last;
    logic [1:0] di;
    logic [1:0] dj;
    coef_e      coef;
  } corner_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_RUN,
    BS_DONE,
    BS_WAIT
  } bstate_e;

  // Multiplies a 5-bit scale by 0..3.
  function automatic logic [6:0] scale_mul(input logic [4:0] s, input logic [1:0] m);
    logic [6:0] r;
    case (m)
      2'd0:    r = 7'd0;
      2'd1:    r = {2'b00, s};
      2'd2:    r = {1'b0, s, 1'b0};
      default: r = {2'b00, s} + {1'b0, s, 1'b0};
    endcase
    return r;
  endfunction

  function automatic corner_t mk(input logic [1:0] di, input logic [1:0] dj,
                                 input coef_e coef, input logic last);
    corner_t c;
    c.last = last;
    c.di   = di;
    c.dj   = dj;
    c.coef = coef;
    return c;
  endfunction

  // Grid corners (in units of the scale) and their weights for each feature.
  function automatic corner_t corner_at(input logic [2:0] kind, input logic [3:0] step);
    corner_t c;
    c = mk(2'd0, 2'd0, COEF_P1, 1'b1);
    case (kind)
      KIND_H2: begin
        case (step)
          4'd0:    c = mk(2'd0, 2'd0, COEF_M1, 1'b0);
          4'd1:    c = mk(2'd1, 2'd0, COEF_P2, 1'b0);
          4'd2:    c = mk(2'd2, 2'd0, COEF_M1, 1'b0);
          4'd3:    c = mk(2'd0, 2'd1, COEF_P1, 1'b0);
          4'd4:    c = mk(2'd1, 2'd1, COEF_M2, 1'b0);
          default: c = mk(2'd2, 2'd1, COEF_P1, 1'b1);
        endcase
      end
      KIND_V2: begin
        case (step)
          4'd0:    c = mk(2'd0, 2'd0, COEF_M1, 1'b0);
          4'd1:    c = mk(2'd0, 2'd1, COEF_P2, 1'b0);
          4'd2:    c = mk(2'd0, 2'd2, COEF_M1, 1'b0);
          4'd3:    c = mk(2'd1, 2'd0, COEF_P1, 1'b0);
          4'd4:    c = mk(2'd1, 2'd1, COEF_M2, 1'b0);
          default: c = mk(2'd1, 2'd2, COEF_P1, 1'b1);
        endcase
      end
      KIND_H3: begin
        case (step)
          4'd0:    c = mk(2'd0, 2'd0, COEF_M1, 1'b0);
          4'd1:    c = mk(2'd1, 2'd0, COEF_P2, 1'b0);
          4'd2:    c = mk(2'd2, 2'd0, COEF_M2, 1'b0);
          4'd3:    c = mk(2'd3, 2'd0, COEF_P1, 1'b0);
          4'd4:    c = mk(2'd0, 2'd1, COEF_P1, 1'b0);
          4'd5:    c = mk(2'd1, 2'd1, COEF_M2, 1'b0);
          4'd6:    c = mk(2'd2, 2'd1, COEF_P2, 1'b0);
          default: c = mk(2'd3, 2'd1, COEF_M1, 1'b1);
        endcase
      end
      KIND_V3: begin
        case (step)
          4'd0:    c = mk(2'd0, 2'd0, COEF_M1, 1'b0);
          4'd1:    c = mk(2'd0, 2'd1, COEF_P2, 1'b0);
          4'd2:    c = mk(2'd0, 2'd2, COEF_M2, 1'b0);
          4'd3:    c = mk(2'd0, 2'd3, COEF_P1, 1'b0);
          4'd4:    c = mk(2'd1, 2'd0, COEF_P1, 1'b0);
          4'd5:    c = mk(2'd1, 2'd1, COEF_M2, 1'b0);
          4'd6:    c = mk(2'd1, 2'd2, COEF_P2, 1'b0);
          default: c = mk(2'd1, 2'd3, COEF_M1, 1'b1);
        endcase
      end
      KIND_F4: begin
        case (step)
          4'd0:    c = mk(2'd0, 2'd0, COEF_P1, 1'b0);
          4'd1:    c = mk(2'd1, 2'd0, COEF_M2, 1'b0);
          4'd2:    c = mk(2'd2, 2'd0, COEF_P1, 1'b0);
          4'd3:    c = mk(2'd0, 2'd1, COEF_M2, 1'b0);
          4'd4:    c = mk(2'd1, 2'd1, COEF_P4, 1'b0);
          4'd5:    c = mk(2'd2, 2'd1, COEF_M2, 1'b0);
          4'd6:    c = mk(2'd0, 2'd2, COEF_P1, 1'b0);
          4'd7:    c = mk(2'd1, 2'd2, COEF_M2, 1'b0);
          default: c = mk(2'd2, 2'd2, COEF_P1, 1'b1);
        endcase
      end
      default: c = mk(2'd0, 2'd0, COEF_P1, 1'b1);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/haar_feature_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// Haar feature evaluator core
// Integral image store with five Haar feature evaluations over its window.
// ----------------------------------------------------------------------------
// Usage: items enter on the in channel (in_valid_i / in_ready_o / in_data_i).
// A load item writes one integral word at load_index; indexes past the window
// are dropped. Loads give no result; the idle back end retires one per cycle.
// An evaluate item gives one transfer on the out channel (out_valid_o /
// out_ready_i / out_data_o) carrying the feature value, or zero with
// out_of_window set when the feature does not fit in the window.
// Evaluation reads the feature's corners from a single-port store, one per
// cycle: 6 corners for two-rectangle, 8 for three-rectangle and 9 for the
// four-rectangle feature. Out-of-window and undefined kinds read no corners;
// they are answered from the idle state once the result register is free.
// A two-entry queue parts the front end from the back end, so new items are
// accepted while an evaluation runs. When the receiver stalls, the result
// register holds, the back end waits, the queue fills and in_ready_o drops.
// Reset empties the queue and the result register; store contents are
// undefined until loaded.
`default_nettype none
`include "haar_feature_evaluator_core_defines.svh"

module haar_feature_evaluator_core #(
  parameter int WINDOW_SIZE = hfe_pkg::DEFAULT_WINDOW_SIZE
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hfe_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output hfe_pkg::out_t      out_data_o
);
  import hfe_pkg::*;

  localparam int DEPTH_WORDS = WINDOW_SIZE * WINDOW_SIZE;
  localparam int AW = $clog2(DEPTH_WORDS);

  // Queue head as seen by the back end.
  logic               head_valid;
  cmd_t               head;
  logic               pop;

  // Store port, driven by the back end.
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;

  hfe_front #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  hfe_back #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The integral image itself.
  hfe_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // The back end never takes a command from an empty queue.
  `HFE_ASSERT_NEVER(a_pop_empty, pop && !head_valid, "pop from empty queue")
  // An out-of-window result always carries a zero value.
  `HFE_ASSERT(a_oow_zero, out_valid_o && out_data_o.out_of_window |-> out_data_o.feature_value == '0, "out-of-window result is not zero")
  // Input back-pressure only comes from a full queue, which has a head.
  `HFE_ASSERT(a_full_head, !in_ready_o |-> head_valid, "queue full without a head")

endmodule

`default_nettype wire

// ----- hw/rtl/hfe_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 576
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hfe_front.sv -----
// ----------------------------------------------------------------------------
// Haar feature evaluator front end
// Accepts items, classifies loads and evaluations, and queues the commands.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_front #(
  parameter int WINDOW_SIZE = hfe_pkg::DEFAULT_WINDOW_SIZE
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hfe_pkg::in_t  in_data_i,
  output logic               head_valid_o,
  output hfe_pkg::cmd_t      head_o,
  input  wire logic          pop_i
);
  import hfe_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH_WORDS = WINDOW_SIZE * WINDOW_SIZE;

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  cmd_t             cmd;
  logic [1:0]       mx, my;
  logic [7:0]       far_x, far_y;
  logic             push, pop;

  always_comb begin
    mx = 2'd2;
    my = 2'd1;
    case (in_data_i.feature_kind)
      KIND_H2: begin mx = 2'd2; my = 2'd1; end
      KIND_V2: begin mx = 2'd1; my = 2'd2; end
      KIND_H3: begin mx = 2'd3; my = 2'd1; end
      KIND_V3: begin mx = 2'd1; my = 2'd3; end
      KIND_F4: begin mx = 2'd2; my = 2'd2; end
      default: begin mx = 2'd0; my = 2'd0; end
    endcase
    far_x = {3'b000, in_data_i.pos_x} + {1'b0, scale_mul(in_data_i.scale_x, mx)};
    far_y = {3'b000, in_data_i.pos_y} + {1'b0, scale_mul(in_data_i.scale_y, my)};

    cmd.is_load    = (in_data_i.req_type == REQ_LOAD);
    cmd.load_ok    = ({6'd0, in_data_i.load_index} < 16'(DEPTH_WORDS));
    cmd.load_index = in_data_i.load_index;
    cmd.load_value = in_data_i.load_value;
    cmd.kind       = in_data_i.feature_kind;
    cmd.pos_x      = in_data_i.pos_x;
    cmd.pos_y      = in_data_i.pos_y;
    cmd.scale_x    = in_data_i.scale_x;
    cmd.scale_y    = in_data_i.scale_y;
    // Undefined kinds report in-window with a zero value.
    if (in_data_i.feature_kind > KIND_F4) begin
      cmd.oow = 1'b0;
    end else begin
      cmd.oow = (far_x > 8'(WINDOW_SIZE - 1)) || (far_y > 8'(WINDOW_SIZE - 1));
    end
    cmd.skip = cmd.oow || (in_data_i.feature_kind > KIND_F4);
  end

  assign in_ready_o   = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hfe_back.sv -----
// ----------------------------------------------------------------------------
// Haar feature evaluator back end
// Writes loads to the store and walks feature corners one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_back #(
  parameter int WINDOW_SIZE = hfe_pkg::DEFAULT_WINDOW_SIZE
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      head_valid_i,
  input  wire hfe_pkg::cmd_t                             head_i,
  output logic                                           pop_o,
  output logic                                           ram_we_o,
  output logic [$clog2(WINDOW_SIZE*WINDOW_SIZE)-1:0]     ram_addr_o,
  output logic [hfe_pkg::VALUE_W-1:0]                    ram_wdata_o,
  input  wire logic [hfe_pkg::VALUE_W-1:0]               ram_rdata_i,
  output logic                                           out_valid_o,
  input  wire logic                                      out_ready_i,
  output hfe_pkg::out_t                                  out_data_o
);
  import hfe_pkg::*;

  localparam int AW = $clog2(WINDOW_SIZE * WINDOW_SIZE);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(524287);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(524288);

  bstate_e                  state_q, state_d;
  logic [3:0]               step_q, step_d;
  cmd_t                     cmd_q, cmd_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     rd_vld_q, rd_vld_d;
  coef_e                    coef_q, coef_d;
  out_t                     out_q, out_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_free;
  corner_t                  cor;
  logic [6:0]               col, row;
  logic [15:0]              addr_full;
  logic signed [ACC_W-1:0]  base, term, final_sum;

  function automatic logic signed [19:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > SAT_MAX) r = SAT_MAX;
    if (v < SAT_MIN) r = SAT_MIN;
    return r[19:0];
  endfunction

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cor       = corner_at(cmd_q.kind, step_q);
    col       = {2'b00, cmd_q.pos_x} + scale_mul(cmd_q.scale_x, cor.di);
    row       = {2'b00, cmd_q.pos_y} + scale_mul(cmd_q.scale_y, cor.dj);
    addr_full = 16'(row) * 16'(WINDOW_SIZE) + 16'(col);

    base = $signed({{(ACC_W-VALUE_W){1'b0}}, ram_rdata_i});
    case (coef_q)
      COEF_P1: term = base;
      COEF_M1: term = -base;
      COEF_P2: term = base <<< 1;
      COEF_M2: term = -(base <<< 1);
      COEF_P4: term = base <<< 2;
      default: term = base;
    endcase
    final_sum = acc_q + term;
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_d       = cmd_q;
    acc_d       = acc_q;
    rd_vld_d    = 1'b0;
    coef_d      = coef_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = addr_full[AW-1:0];
    ram_wdata_o = head_i.load_value;

    case (state_q)
      BS_IDLE: begin
        ram_addr_o = AW'(head_i.load_index);
        if (head_valid_i) begin
          if (head_i.is_load) begin
            pop_o    = 1'b1;
            ram_we_o = head_i.load_ok;
          end else if (head_i.skip) begin
            if (out_free) begin
              pop_o                   = 1'b1;
              out_d.feature_value     = '0;
              out_d.out_of_window     = head_i.oow;
              out_valid_d             = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            cmd_d   = head_i;
            step_d  = '0;
            acc_d   = '0;
            state_d = BS_RUN;
          end
        end
      end
      BS_RUN: begin
        // Read one corner per cycle; its weight lines up with the data next cycle.
        if (rd_vld_q) begin
          acc_d = final_sum;
        end
        rd_vld_d = 1'b1;
        coef_d   = cor.coef;
        step_d   = step_q + 4'd1;
        if (cor.last) begin
          state_d = BS_DONE;
        end
      end
      BS_DONE: begin
        acc_d = final_sum;
        if (out_free) begin
          out_d.feature_value = sat(final_sum);
          out_d.out_of_window = 1'b0;
          out_valid_d         = 1'b1;
          state_d             = BS_IDLE;
        end else begin
          state_d = BS_WAIT;
        end
      end
      BS_WAIT: begin
        if (out_free) begin
          out_d.feature_value = sat(acc_q);
          out_d.out_of_window = 1'b0;
          out_valid_d         = 1'b1;
          state_d             = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    cmd_q  <= cmd_d;
    acc_q  <= acc_d;
    coef_q <= coef_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_haar_feature_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// Haar feature evaluator core testbench
// Loads integral images, evaluates every feature kind at random positions and
// scales, and checks each result against a behavioral model of the feature
// arithmetic, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_haar_feature_evaluator_core;
  import hfe_pkg::*;

  localparam int WIN = DEFAULT_WINDOW_SIZE;
  localparam int DEPTH = WIN * WIN;
  localparam int OUT_MAX = 524287;
  localparam int OUT_MIN = -524288;
  localparam logic REQ_EVAL = 1'b1;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  haar_feature_evaluator_core dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the integral store.
  logic [17:0] shadow_store[DEPTH];

  in_t pending_items[$];
  out_t expected_features[$];

  int idle_pct_in = 0;
  int idle_pct_out = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int cycles = 0;
  bit sent_flag;

  // Reads one integral word; the stimulus never reaches unwritten words.
  function automatic longint word_at(int col, int row);
    if (col >= WIN || row >= WIN) return 0;
    return longint'(shadow_store[col + row * WIN]);
  endfunction

  function automatic longint rect_total(int x, int y, int w, int h);
    return word_at(x + w, y + h) - word_at(x, y + h) - word_at(x + w, y) + word_at(x, y);
  endfunction

  // Applies one item to the shadow state; returns 1 with the feature result
  // for evaluations.
  function automatic bit apply_item(in_t it, output out_t res);
    int x, y, sx, sy, mx, my;
    longint v;
    bit oow;
    res = '0;
    if (it.req_type == REQ_LOAD) begin
      if (it.load_index < DEPTH) begin
        shadow_store[it.load_index] = it.load_value;
      end
      return 1'b0;
    end
    x = it.pos_x; y = it.pos_y; sx = it.scale_x; sy = it.scale_y;
    v = 0; oow = 1'b0;
    if (it.feature_kind <= KIND_F4) begin
      mx = (it.feature_kind == KIND_H3) ? 3 :
           (it.feature_kind == KIND_V2 || it.feature_kind == KIND_V3) ? 1 : 2;
      my = (it.feature_kind == KIND_V3) ? 3 :
           (it.feature_kind == KIND_H2 || it.feature_kind == KIND_H3) ? 1 : 2;
      oow = (x + mx * sx > WIN - 1) || (y + my * sy > WIN - 1);
      if (!oow) begin
        case (it.feature_kind)
          KIND_H2: v = rect_total(x + sx, y, sx, sy) - rect_total(x, y, sx, sy);
          KIND_V2: v = rect_total(x, y + sy, sx, sy) - rect_total(x, y, sx, sy);
          KIND_H3: v = rect_total(x + sx, y, sx, sy) - rect_total(x, y, sx, sy)
                       - rect_total(x + 2 * sx, y, sx, sy);
          KIND_V3: v = rect_total(x, y + sy, sx, sy) - rect_total(x, y, sx, sy)
                       - rect_total(x, y + 2 * sy, sx, sy);
          default: v = rect_total(x, y, sx, sy) + rect_total(x + sx, y + sy, sx, sy)
                       - rect_total(x + sx, y, sx, sy) - rect_total(x, y + sy, sx, sy);
        endcase
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < OUT_MIN) v = OUT_MIN;
      end
    end
    res.feature_value = v[19:0];
    res.out_of_window = oow;
    return 1'b1;
  endfunction

  // Driver: the payload changes at the falling edge, a valid one only after its transfer.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || sent_flag) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct_in) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready changes at the falling edge; a pending hold keeps it low
  // until the hold count runs out.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct_out);
      end
    end
  end

  // Monitor: a transfer is seen at the rising edge; the model runs on accept.
  always @(posedge clk) begin
    out_t res;
    out_t want;
    sent_flag <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (in_valid && in_ready) begin
        if (apply_item(in_data, res)) expected_features.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (expected_features.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_features.pop_front();
          if (out_data.feature_value !== want.feature_value ||
              out_data.out_of_window !== want.out_of_window) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected value %0d oow %0b, got value %0d oow %0b",
                       want.feature_value, want.out_of_window,
                       out_data.feature_value, out_data.out_of_window);
          end
        end
      end
    end
  end

  function automatic in_t load_item(int idx, int val);
    in_t it;
    it = '0;
    it.req_type = REQ_LOAD;
    it.load_index = idx[9:0];
    it.load_value = val[17:0];
    it.feature_kind = $urandom_range(7);
    it.pos_x = $urandom_range(31);
    it.pos_y = $urandom_range(31);
    it.scale_x = $urandom_range(31);
    it.scale_y = $urandom_range(31);
    return it;
  endfunction

  function automatic in_t eval_item(int kind, int x, int y, int sx, int sy);
    in_t it;
    it = '0;
    it.req_type = REQ_EVAL;
    it.load_index = $urandom_range(1023);
    it.load_value = $urandom_range(262143);
    it.feature_kind = kind[2:0];
    it.pos_x = x[4:0];
    it.pos_y = y[4:0];
    it.scale_x = sx[4:0];
    it.scale_y = sy[4:0];
    return it;
  endfunction

  // Waits until every queued item went out and every result came back.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_features.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int n;
    int kind;
    // Limit on the whole run; a hang ends here.
    fork
      begin
        wait (cycles >= MAX_CYCLES);
        $display("*** FAILED ***");
        $finish;
      end
    join_none
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: a full image of extremes, so no evaluation ever reads an
    // unwritten word afterwards. Loads past the window must be ignored.
    for (int i = 0; i < DEPTH; i++)
      pending_items.push_back(load_item(i, (i % 3 == 0) ? 262143 : (i % 3 == 1) ? 0 : i * 255));
    pending_items.push_back(load_item(DEPTH, 5));
    pending_items.push_back(load_item(1023, 262143));
    for (int k = 0; k < 8; k++) pending_items.push_back(eval_item(k, 0, 0, 1, 1));
    pending_items.push_back(eval_item(KIND_F4, 0, 0, 11, 11));
    pending_items.push_back(eval_item(KIND_H3, 0, 0, 7, 23));
    pending_items.push_back(eval_item(KIND_V3, 0, 0, 23, 7));
    pending_items.push_back(eval_item(KIND_H2, 23, 23, 0, 0));
    pending_items.push_back(eval_item(KIND_V2, 31, 31, 31, 31));
    pending_items.push_back(eval_item(KIND_F4, 0, 0, 12, 12));
    pending_items.push_back(eval_item(KIND_H2, 5, 3, 0, 4));
    pending_items.push_back(eval_item(KIND_V3, 2, 1, 3, 0));
    drain();

    // Random part over four idling phases. Random overwrites of the image
    // give values far outside a true integral image and exercise saturation.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct_in = (ph == 1 || ph == 3) ? 47 : 0;
      idle_pct_out = (ph == 2 || ph == 3) ? 47 : 0;
      idle_pct_in = (ph == 3) ? 6 : idle_pct_in;
      idle_pct_out = (ph == 3) ? 6 : idle_pct_out;
      if (ph == 1) hold_cycles = 300;
      n = 0;
      while (n < 165) begin
        if ($urandom_range(9) < 2) begin
          pending_items.push_back(load_item($urandom_range(1023), $urandom_range(262143)));
        end else begin
          kind = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(4);
          if ($urandom_range(3) == 0)
            pending_items.push_back(eval_item(kind, $urandom_range(31), $urandom_range(31),
                                              $urandom_range(31), $urandom_range(31)));
          else
            pending_items.push_back(eval_item(kind, $urandom_range(12), $urandom_range(12),
                                              $urandom_range(6), $urandom_range(6)));
        end
        n++;
      end
      drain();
    end

    if (mismatches == 0 && expected_features.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/hfe_pkg.sv
hw/rtl/hfe_ram.sv
hw/rtl/hfe_front.sv
hw/rtl/hfe_back.sv
hw/rtl/haar_feature_evaluator_core.sv
tb/sv/tb_haar_feature_evaluator_core.sv
